// ----- rtl/core/scet_pkg.sv -----
// package for the seam cumulative energy trace unit
// holds widths, codes, controller state and command types; no dependencies
package scet_pkg;
  localparam int MaxWidth = 256;
  localparam int MaxHeight = 256;
  localparam int ColW = $clog2(MaxWidth);
  localparam int RowW = $clog2(MaxHeight);
  localparam int CntW = RowW + 1;
  localparam int DimW = 9;
  localparam int AddrW = RowW + ColW;
  localparam int EnW = 15;
  localparam int CostW = 24;
  localparam int CfgIdxW = 1;
  localparam logic [CostW-1:0] CostMax = '1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TRACE = 1'b1;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LRD, ST_LCMP, ST_TSCAN, ST_TRD, ST_TCMP, ST_OUT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic           rd_en;
    logic [RowW-1:0] rd_row;
    logic [ColW-1:0] rd_col;
    logic           rd_nb;   // read lands in neighbor slot
    logic [1:0]     slot;
    logic           wr_en;
    logic [RowW-1:0] wr_row;
    logic [ColW-1:0] wr_col;
    logic           scan_first;
    logic           scan_upd;
  } dp_cmd_t;

  typedef struct packed {
    logic [CostW-1:0] sum;
    logic [CostW-1:0] best;
    logic [1:0]       pick; // 0 mid, 1 left, 2 right
    logic             scan_less;
  } dp_sts_t;
endpackage

// ----- rtl/core/scet_if.sv -----
// valid/ready stream interface carrying a payload of configurable type
// used by all channels; depends on nothing
interface scet_stream_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/scet_datapath.sv -----
// cost store memory, saturating adder and min compare for the unit
// depends on scet_pkg
module scet_datapath (
  input  logic                       clk,
  input  scet_pkg::dp_cmd_t          cmd,
  input  logic [scet_pkg::EnW-1:0]   energy,
  input  logic                       first_row,
  input  logic                       has_l,
  input  logic                       has_r,
  output scet_pkg::dp_sts_t          sts
);
  import scet_pkg::*;

  logic [CostW-1:0] mem [0:(1<<AddrW)-1];
  logic [CostW-1:0] rd_q;
  logic             rd_nb_r;
  logic [1:0]       slot_r;
  logic             rd_v_r;
  logic [CostW-1:0] nb_r [0:2];
  logic [CostW-1:0] best_r;
  logic [CostW:0]   sum_w;
  logic [CostW-1:0] mn;
  logic [1:0]       pk;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[{cmd.wr_row, cmd.wr_col}] <= sts.sum;
    if (cmd.rd_en) rd_q <= mem[{cmd.rd_row, cmd.rd_col}];
    rd_v_r  <= cmd.rd_en;
    rd_nb_r <= cmd.rd_nb;
    slot_r  <= cmd.slot;
    if (rd_v_r && rd_nb_r) nb_r[slot_r] <= rd_q;
    if (cmd.scan_first) best_r <= rd_q;
    else if (cmd.scan_upd && rd_q < best_r) best_r <= rd_q;
  end

  always_comb begin
    mn = nb_r[0];
    pk = 2'd0;
    if (has_l && nb_r[1] < mn) begin
      mn = nb_r[1];
      pk = 2'd1;
    end
    if (has_r && nb_r[2] < mn) begin
      mn = nb_r[2];
      pk = 2'd2;
    end
    sum_w = {{(CostW+1-EnW){1'b0}}, energy} + (first_row ? '0 : {1'b0, mn});
    sts.sum = sum_w[CostW] ? CostMax : sum_w[CostW-1:0];
    sts.best = mn;
    sts.pick = pk;
    sts.scan_less = rd_q < best_r;
  end
endmodule

// ----- rtl/core/scet_ctrl.sv -----
// controller: counters, handshakes and sequencing of datapath reads
// depends on scet_pkg and scet_if
module scet_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  scet_stream_if.sink           in_ch,
  scet_stream_if.sink           cfg_ch,
  scet_stream_if.source         out_ch,
  output scet_pkg::dp_cmd_t     cmd,
  output logic [scet_pkg::EnW-1:0] energy,
  output logic                  first_row,
  output logic                  has_l,
  output logic                  has_r,
  input  scet_pkg::dp_sts_t     sts
);
  import scet_pkg::*;

  state_t state_r, state_nxt;
  logic [DimW-1:0] wcfg_r, hcfg_r;
  logic [CntW-1:0] lrow_r, lrow_nxt, trow_r, trow_nxt;
  logic [ColW-1:0] lcol_r, lcol_nxt, tcol_r, tcol_nxt;
  logic [CntW-1:0] w, h;
  logic [1:0] step_r, step_nxt;
  logic [ColW:0] scol_r, scol_nxt;
  logic [ColW-1:0] spick_r, spick_nxt;
  logic [ColW-1:0] tc;
  logic [EnW-1:0] en_r, en_nxt;
  logic [CostW-1:0] ocost_r, ocost_nxt;
  logic [ColW-1:0] ocol_r, ocol_nxt;
  logic oerr_r, oerr_nxt, olast_r, olast_nxt;
  logic [RowW-1:0] rcur;
  logic in_xfer;

  assign w = (wcfg_r == '0) ? CntW'(1) : (wcfg_r > DimW'(MaxWidth)) ? CntW'(MaxWidth)
           : CntW'(wcfg_r);
  assign h = (hcfg_r == '0) ? CntW'(1) : (hcfg_r > DimW'(MaxHeight)) ? CntW'(MaxHeight)
           : CntW'(hcfg_r);
  assign rcur = RowW'(h - CntW'(1) - lrow_r);
  assign tc = ({1'b0, tcol_r} >= w) ? ColW'(w - CntW'(1)) : tcol_r;
  assign energy = en_r;
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = (state_r == ST_IDLE);
  assign out_ch.valid = (state_r == ST_OUT);
  assign out_ch.data = {ocost_r, ocol_r, oerr_r, olast_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wcfg_r <= DimW'(256);
      hcfg_r <= DimW'(256);
      lrow_r <= '0; lcol_r <= '0; trow_r <= '0; tcol_r <= '0;
      step_r <= '0;
    end else begin
      state_r <= state_nxt;
      lrow_r <= lrow_nxt; lcol_r <= lcol_nxt;
      trow_r <= trow_nxt; tcol_r <= tcol_nxt;
      step_r <= step_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        lrow_r <= '0; lcol_r <= '0; trow_r <= '0; tcol_r <= '0;
        unique case (cfg_ch.data[DimW +: CfgIdxW])
          CFG_WIDTH:  wcfg_r <= cfg_ch.data[DimW-1:0];
          CFG_HEIGHT: hcfg_r <= cfg_ch.data[DimW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    scol_r <= scol_nxt; spick_r <= spick_nxt; en_r <= en_nxt;
    ocost_r <= ocost_nxt; ocol_r <= ocol_nxt; oerr_r <= oerr_nxt; olast_r <= olast_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    lrow_nxt = lrow_r; lcol_nxt = lcol_r; trow_nxt = trow_r; tcol_nxt = tcol_r;
    step_nxt = step_r; scol_nxt = scol_r; spick_nxt = spick_r; en_nxt = en_r;
    ocost_nxt = ocost_r; ocol_nxt = ocol_r; oerr_nxt = oerr_r; olast_nxt = olast_r;
    cmd = '0;
    in_ch.ready = (state_r == ST_IDLE) && !cfg_ch.valid;
    first_row = (lrow_r == '0);
    has_l = 1'b0;
    has_r = 1'b0;
    unique case (state_r)
      ST_IDLE: if (in_xfer) begin
        ocost_nxt = '0; ocol_nxt = '0; oerr_nxt = 1'b0; olast_nxt = 1'b0;
        en_nxt = in_ch.data[EnW-1:0];
        step_nxt = '0;
        if (in_ch.data[EnW] == OP_LOAD) begin
          if (lrow_r >= h && trow_r >= h) begin
            lrow_nxt = '0; lcol_nxt = '0; trow_nxt = '0; tcol_nxt = '0;
            state_nxt = ST_LRD;
          end else if (lrow_r >= h || {1'b0, lcol_r} >= w) begin
            oerr_nxt = 1'b1;
            state_nxt = ST_OUT;
          end else state_nxt = ST_LRD;
        end else begin
          if (lrow_r < h || trow_r >= h) begin
            oerr_nxt = 1'b1;
            state_nxt = ST_OUT;
          end else if (trow_r == '0) begin
            scol_nxt = '0; spick_nxt = '0;
            state_nxt = ST_TSCAN;
          end else state_nxt = ST_TRD;
        end
      end
      // read mid, left, right of the row below, one per cycle
      ST_LRD: begin
        cmd.rd_en = !first_row;
        cmd.rd_nb = 1'b1;
        cmd.slot = step_r;
        cmd.rd_row = RowW'(rcur + RowW'(1));
        cmd.rd_col = (step_r == 2'd1) ? lcol_r - ColW'(1)
                   : (step_r == 2'd2) ? lcol_r + ColW'(1) : lcol_r;
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd2) state_nxt = ST_LCMP;
      end
      ST_LCMP: begin
        // waits for last read to land, then commits
        step_nxt = step_r + 2'd1;
        has_l = lcol_r != '0;
        has_r = ({1'b0, lcol_r} + (ColW+1)'(1)) < (ColW+1)'(w);
        if (step_r == 2'd0) begin
          cmd.wr_en = 1'b1;
          cmd.wr_row = rcur;
          cmd.wr_col = lcol_r;
          ocost_nxt = sts.sum;
          if (({1'b0, lcol_r} + (ColW+1)'(1)) >= (ColW+1)'(w)) begin
            lcol_nxt = '0;
            lrow_nxt = lrow_r + CntW'(1);
            olast_nxt = (lrow_r + CntW'(1)) >= h;
          end else lcol_nxt = lcol_r + ColW'(1);
          state_nxt = ST_OUT;
        end
      end
      // walk row 0: issue read at scol, compare the read issued the cycle before
      ST_TSCAN: begin
        if (scol_r < (ColW+1)'(w)) begin
          cmd.rd_en = 1'b1;
          cmd.rd_col = scol_r[ColW-1:0];
          scol_nxt = scol_r + (ColW+1)'(1);
        end
        step_nxt = (step_r == 2'd2) ? 2'd2 : step_r + 2'd1;
        if (step_r == 2'd1) cmd.scan_first = 1'b1;
        else if (step_r == 2'd2) begin
          cmd.scan_upd = 1'b1;
          if (sts.scan_less) spick_nxt = ColW'(scol_r - (ColW+1)'(1));
        end
        // done once final compare of column w-1 happens this cycle
        if ((step_r == 2'd2 && scol_r == (ColW+1)'(w)) ||
            (step_r == 2'd1 && w == CntW'(1))) begin
          tcol_nxt = (step_r == 2'd2 && sts.scan_less) ? ColW'(scol_r - (ColW+1)'(1))
                   : spick_r;
          if (step_r == 2'd1) tcol_nxt = '0;
          ocol_nxt = tcol_nxt;
          trow_nxt = trow_r + CntW'(1);
          olast_nxt = (trow_r + CntW'(1)) >= h;
          state_nxt = ST_OUT;
        end
      end
      ST_TRD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_nb = 1'b1;
        cmd.slot = step_r;
        cmd.rd_row = trow_r[RowW-1:0];
        cmd.rd_col = (step_r == 2'd1) ? tc - ColW'(1)
                   : (step_r == 2'd2) ? tc + ColW'(1) : tc;
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd2) begin
          step_nxt = '0;
          state_nxt = ST_TCMP;
        end
      end
      ST_TCMP: begin
        has_l = tc != '0;
        has_r = ({1'b0, tc} + (ColW+1)'(1)) < (ColW+1)'(w);
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd1) begin
          tcol_nxt = (sts.pick == 2'd1) ? tc - ColW'(1)
                   : (sts.pick == 2'd2) ? tc + ColW'(1) : tc;
          ocol_nxt = tcol_nxt;
          trow_nxt = trow_r + CntW'(1);
          olast_nxt = (trow_r + CntW'(1)) >= h;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: if (out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// ----- rtl/core/seam_cumulative_energy_trace_unit.sv -----
// Seam-carving cumulative cost builder and vertical seam tracer. One item is
// handled at a time through the cost store. A load goes from idle through three
// neighbor reads of the row below and a compare that waits for the last read and
// then writes, to output; a trace of a later row reads three neighbors and
// compares likewise, without the write; a misuse item goes from idle straight to
// output; the first trace walks row 0 at one column per cycle. Results sit in an
// output register until taken.
// top level; depends on scet_pkg, scet_if, scet_ctrl, scet_datapath
module seam_cumulative_energy_trace_unit (
  input logic           clk,
  input logic           rst_n,
  scet_stream_if.sink   in_ch,
  scet_stream_if.sink   cfg_ch,
  scet_stream_if.source out_ch
);
  import scet_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [EnW-1:0] energy;
  logic first_row, has_l, has_r;

  scet_ctrl u_ctrl (
    .clk, .rst_n, .in_ch, .cfg_ch, .out_ch,
    .cmd, .energy, .first_row, .has_l, .has_r, .sts
  );

  scet_datapath u_dp (
    .clk, .cmd, .energy, .first_row, .has_l, .has_r, .sts
  );
endmodule
